// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the downmix RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/sdm_pkg.sv =====
// Types and constants for the surround to stereo downmix.
// No dependencies.
`timescale 1ns / 1ps
package sdm_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int COEF_W        = 18;
   localparam int ACC_W         = 32;
   localparam int PROD_W        = SAMPLE_W + COEF_W;
   localparam int COUNT_W       = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 2;
   localparam int FRAC_BITS_DEF = 12;
   localparam int SLOTS         = 8;   // four products per output side

   localparam logic [CSR_ADDR_W-1:0] ADDR_MIX_MODE = '0;

   typedef enum logic [2:0] {
      MODE_SURR_32    = 3'd0,
      MODE_SURR2_32   = 3'd1,
      MODE_SURR_22    = 3'd2,
      MODE_SURR2_22   = 3'd3,
      MODE_3F         = 3'd4,
      MODE_3F1R       = 3'd5,
      MODE_MONO_DUP   = 3'd6,
      MODE_STEREO_MIX = 3'd7
   } mix_mode_type;

   localparam logic [COUNT_W-1:0] COUNT_MONO   = 2'd1;
   localparam logic [COUNT_W-1:0] COUNT_STEREO = 2'd2;

endpackage

// ===== rtl/surround_to_stereo_downmix.sv =====
// Surround to stereo downmix: fixed-matrix mixing of one multichannel frame per word.
// Depends on sdm_pkg and assert_macros.svh.
// start passes through v1_ff, v2_ff, v3_ff and v4_ff to rsp_valid; one word per cycle, busy stays low.
// Stages: operand/coefficient select, products, pair sums, final sum and output register.
// Synchronous reset clears mix_mode to 0 and all valid bits; no result is in flight after it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module surround_to_stereo_downmix #(
   parameter int FRAC_BITS = sdm_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [sdm_pkg::SAMPLE_W-1:0]   req_chan0,
   input  logic signed [sdm_pkg::SAMPLE_W-1:0]   req_chan1,
   input  logic signed [sdm_pkg::SAMPLE_W-1:0]   req_chan2,
   input  logic signed [sdm_pkg::SAMPLE_W-1:0]   req_chan3,
   input  logic signed [sdm_pkg::SAMPLE_W-1:0]   req_chan4,
   input  logic signed [sdm_pkg::SAMPLE_W-1:0]   req_chan5,
   output logic                                  rsp_valid,
   output logic signed [sdm_pkg::SAMPLE_W-1:0]   rsp_out_left,
   output logic signed [sdm_pkg::SAMPLE_W-1:0]   rsp_out_right,
   output logic        [sdm_pkg::COUNT_W-1:0]    rsp_out_count,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic        [sdm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic        [sdm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic        [sdm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                  pready
);
   import sdm_pkg::*;

   // coefficients: truncation of (2 << FRAC_BITS) * factor
   localparam longint Scale = longint'(2) << FRAC_BITS;
   localparam longint KaL   = (Scale * 3225) / 10000;
   localparam longint KbL   = (Scale * 3225 * 707) / 10000000;
   localparam longint KcL   = (Scale * 3225 * 8165) / 100000000;
   localparam longint KdL   = (Scale * 3225 * 5774) / 100000000;

   localparam logic signed [COEF_W-1:0] KA  = COEF_W'(KaL);
   localparam logic signed [COEF_W-1:0] KB  = COEF_W'(KbL);
   localparam logic signed [COEF_W-1:0] KC  = COEF_W'(KcL);
   localparam logic signed [COEF_W-1:0] KD  = COEF_W'(KdL);
   localparam logic signed [COEF_W-1:0] KBN = COEF_W'(-KbL);
   localparam logic signed [COEF_W-1:0] KCN = COEF_W'(-KcL);
   localparam logic signed [COEF_W-1:0] KDN = COEF_W'(-KdL);

   // config register
   mix_mode_type mode_ff, mode_in;
   logic         csr_wr;

   // stage 1: selected operands
   logic                       v1_ff;
   logic signed [SAMPLE_W-1:0] opnd_ff [SLOTS];
   logic signed [SAMPLE_W-1:0] opnd_in [SLOTS];
   logic signed [COEF_W-1:0]   coef_ff [SLOTS];
   logic signed [COEF_W-1:0]   coef_in [SLOTS];
   logic                       pass1_ff, mono1_ff;
   logic signed [SAMPLE_W-1:0] smp1_ff;

   // stage 2: products
   logic                       v2_ff;
   logic signed [PROD_W-1:0]   prod_full [SLOTS];
   logic        [ACC_W-1:0]    prod_ff [SLOTS];
   logic                       pass2_ff, mono2_ff;
   logic signed [SAMPLE_W-1:0] smp2_ff;

   // stage 3: pair sums, 0/1 left, 2/3 right
   logic                       v3_ff;
   logic        [ACC_W-1:0]    pair_ff [4];
   logic                       pass3_ff, mono3_ff;
   logic signed [SAMPLE_W-1:0] smp3_ff;

   // stage 4: output word
   logic                       v4_ff;
   logic        [ACC_W-1:0]    sum_l, sum_r;
   logic signed [SAMPLE_W-1:0] left_ff, left_in, right_ff, right_in;
   logic        [COUNT_W-1:0]  count_ff, count_in;

   logic accept;

   assign accept = start && !busy;
   assign busy   = 1'b0;
   assign pready = 1'b1;

   // ---------------- config port ----------------
   assign csr_wr  = psel && penable && pwrite && pready && (paddr == ADDR_MIX_MODE);
   assign mode_in = mix_mode_type'(pwdata[2:0]);
   assign prdata  = (paddr == ADDR_MIX_MODE) ? {{(CSR_DATA_W-3){1'b0}}, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SURR_32;
      end else if (csr_wr) begin
         mode_ff <= mode_in;
      end
   end

   // ---------------- stage 1: matrix slot select ----------------
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         opnd_in[i] = '0;
         coef_in[i] = '0;
      end
      unique case (mode_ff)
         MODE_SURR_32: begin
            opnd_in[0] = req_chan0; coef_in[0] = KA;
            opnd_in[1] = req_chan1; coef_in[1] = KB;
            opnd_in[2] = req_chan3; coef_in[2] = KBN;
            opnd_in[3] = req_chan4; coef_in[3] = KBN;
            opnd_in[4] = req_chan2; coef_in[4] = KA;
            opnd_in[5] = req_chan1; coef_in[5] = KB;
            opnd_in[6] = req_chan3; coef_in[6] = KB;
            opnd_in[7] = req_chan4; coef_in[7] = KB;
         end
         MODE_SURR2_32: begin
            opnd_in[0] = req_chan0; coef_in[0] = KA;
            opnd_in[1] = req_chan1; coef_in[1] = KB;
            opnd_in[2] = req_chan3; coef_in[2] = KCN;
            opnd_in[3] = req_chan4; coef_in[3] = KDN;
            opnd_in[4] = req_chan2; coef_in[4] = KA;
            opnd_in[5] = req_chan1; coef_in[5] = KB;
            opnd_in[6] = req_chan3; coef_in[6] = KD;
            opnd_in[7] = req_chan4; coef_in[7] = KC;
         end
         MODE_SURR_22: begin
            opnd_in[0] = req_chan0; coef_in[0] = KA;
            opnd_in[1] = req_chan2; coef_in[1] = KBN;
            opnd_in[2] = req_chan3; coef_in[2] = KBN;
            opnd_in[4] = req_chan1; coef_in[4] = KA;
            opnd_in[5] = req_chan2; coef_in[5] = KB;
            opnd_in[6] = req_chan3; coef_in[6] = KB;
         end
         MODE_SURR2_22: begin
            opnd_in[0] = req_chan0; coef_in[0] = KA;
            opnd_in[1] = req_chan2; coef_in[1] = KCN;
            opnd_in[2] = req_chan3; coef_in[2] = KDN;
            opnd_in[4] = req_chan1; coef_in[4] = KA;
            opnd_in[5] = req_chan3; coef_in[5] = KC;
            opnd_in[6] = req_chan2; coef_in[6] = KD;
         end
         MODE_3F: begin
            opnd_in[0] = req_chan0; coef_in[0] = KA;
            opnd_in[1] = req_chan1; coef_in[1] = KB;
            opnd_in[4] = req_chan2; coef_in[4] = KA;
            opnd_in[5] = req_chan1; coef_in[5] = KB;
         end
         MODE_3F1R: begin
            opnd_in[0] = req_chan0; coef_in[0] = KA;
            opnd_in[1] = req_chan1; coef_in[1] = KB;
            opnd_in[2] = req_chan3; coef_in[2] = KBN;
            opnd_in[4] = req_chan2; coef_in[4] = KA;
            opnd_in[5] = req_chan1; coef_in[5] = KB;
            opnd_in[6] = req_chan3; coef_in[6] = KB;
         end
         MODE_MONO_DUP, MODE_STEREO_MIX: begin
            // passthrough modes use the sample bypass, products stay zero
         end
         default: begin
         end
      endcase
   end

   // LFE is never mixed; keep it out of the datapath
   logic lfe_unused;
   assign lfe_unused = ^req_chan5;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         opnd_ff[i] <= opnd_in[i];
         coef_ff[i] <= coef_in[i];
      end
      pass1_ff <= (mode_ff == MODE_MONO_DUP) || (mode_ff == MODE_STEREO_MIX) || lfe_unused
                  && 1'b0;
      mono1_ff <= (mode_ff == MODE_STEREO_MIX);
      smp1_ff  <= req_chan0;
   end

   // ---------------- stage 2: products ----------------
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         prod_full[i] = PROD_W'(opnd_ff[i]) * PROD_W'(coef_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         prod_ff[i] <= prod_full[i][ACC_W-1:0];
      end
      pass2_ff <= pass1_ff;
      mono2_ff <= mono1_ff;
      smp2_ff  <= smp1_ff;
   end

   // ---------------- stage 3: pair sums (wrap at 32 bits) ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         pair_ff[i] <= prod_ff[2*i] + prod_ff[2*i+1];
      end
      pass3_ff <= pass2_ff;
      mono3_ff <= mono2_ff;
      smp3_ff  <= smp2_ff;
   end

   // ---------------- stage 4: final sum, scale, output word ----------------
   assign sum_l = pair_ff[0] + pair_ff[1];
   assign sum_r = pair_ff[2] + pair_ff[3];

   always_comb begin
      if (pass3_ff) begin
         left_in  = smp3_ff;
         right_in = mono3_ff ? '0 : smp3_ff;
      end else begin
         // arithmetic shift then keep 16 bits is just a bit slice
         left_in  = sum_l[FRAC_BITS +: SAMPLE_W];
         right_in = sum_r[FRAC_BITS +: SAMPLE_W];
      end
      count_in = mono3_ff ? COUNT_MONO : COUNT_STEREO;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      count_ff <= count_in;
   end

   assign rsp_valid     = v4_ff;
   assign rsp_out_left  = left_ff;
   assign rsp_out_right = right_ff;
   assign rsp_out_count = count_ff;

   // ---------------- assertions ----------------
   `ASSERT_IMPLY(a_valid_from_start, clock, reset, rsp_valid, $past(start && !busy, 4), "result word without a matching start 4 cycles earlier")
   `ASSERT_IMPLY(a_mono_right_zero, clock, reset, rsp_valid && (rsp_out_count == COUNT_MONO), rsp_out_right == '0, "mono word has nonzero right sample")
   `ASSERT_IMPLY(a_count_mode, clock, reset, rsp_valid, (rsp_out_count == COUNT_MONO) == (mode_ff == MODE_STEREO_MIX), "output count disagrees with mix mode")
   `ASSERT_IMPLY(a_dup_equal, clock, reset, rsp_valid && (mode_ff == MODE_MONO_DUP), rsp_out_left == rsp_out_right, "mono to stereo word has unequal sides")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for surround_to_stereo_downmix: directed corner frames, then random phases.
// Depends on sdm_pkg and the downmix RTL; carries its own bit-exact model of the mixing matrices.
`timescale 1ns / 1ps
module tb_top;
   import sdm_pkg::*;

   localparam longint unsigned MIX_SCALE = 64'd2 << FRAC_BITS_DEF;
   localparam bit [31:0] GAIN_A = 32'(MIX_SCALE * 3225 / 10000);
   localparam bit [31:0] GAIN_B = 32'(MIX_SCALE * 3225 * 707 / 10000000);
   localparam bit [31:0] GAIN_C = 32'(MIX_SCALE * 3225 * 8165 / 100000000);
   localparam bit [31:0] GAIN_D = 32'(MIX_SCALE * 3225 * 5774 / 100000000);
   localparam int N_CORNER = 23;
   localparam int N_PHASES = 16;
   localparam int PHASE_WORDS = 119;

   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic [COUNT_W-1:0]  count;
   } mix_word_type;

   typedef struct packed {
      mix_mode_type        mode;
      logic [SAMPLE_W-1:0] c0, c1, c2, c3, c4, c5;
      bit                  pinned;
      mix_word_type        want;
   } corner_row_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [SAMPLE_W-1:0] req_chan0, req_chan1, req_chan2, req_chan3, req_chan4, req_chan5;
   logic                      rsp_valid;
   logic signed [SAMPLE_W-1:0] rsp_out_left, rsp_out_right;
   logic [COUNT_W-1:0]        rsp_out_count;
   logic                      psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0]     paddr;
   logic [CSR_DATA_W-1:0]     pwdata, prdata;
   logic                      pready;

   mix_word_type pending_mix[$];
   mix_mode_type mode_now = MODE_SURR_32;
   mix_word_type pin_word;
   bit           pin_on = 0;
   int           words_taken = 0;
   int           csr_done = 0;
   int           error_count = 0;

   corner_row_type corner_rows [0:N_CORNER-1] = '{
      '{MODE_SURR_32, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
        '{16'h0000, 16'h0000, COUNT_STEREO}},
      '{MODE_SURR_32, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, '0},
      '{MODE_SURR_32, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 1'b0, '0},
      '{MODE_SURR_32, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 1'b0, '0},
      '{MODE_SURR2_32, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0},
      '{MODE_SURR2_32, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, '0},
      '{MODE_SURR2_32, 16'h0001, 16'hFFFF, 16'h1234, 16'hEDCB, 16'h00FF, 16'h0000, 1'b0, '0},
      '{MODE_SURR_22, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, '0},
      '{MODE_SURR_22, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, '0},
      '{MODE_SURR2_22, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, '0},
      '{MODE_SURR2_22, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, '0},
      '{MODE_3F, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
      '{MODE_3F, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0},
      '{MODE_3F1R, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0, '0},
      '{MODE_3F1R, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, '0},
      '{MODE_MONO_DUP, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1,
        '{16'h7FFF, 16'h7FFF, COUNT_STEREO}},
      '{MODE_MONO_DUP, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
        '{16'h8000, 16'h8000, COUNT_STEREO}},
      '{MODE_MONO_DUP, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
        '{16'h0000, 16'h0000, COUNT_STEREO}},
      // mono output: right stays zero whatever the other channels hold
      '{MODE_STEREO_MIX, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
        '{16'h8000, 16'h0000, COUNT_MONO}},
      '{MODE_STEREO_MIX, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
        '{16'h7FFF, 16'h0000, COUNT_MONO}},
      '{MODE_STEREO_MIX, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
        '{16'hFFFF, 16'h0000, COUNT_MONO}},
      // tiny values: shift rounds toward minus infinity
      '{MODE_SURR_32, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0, '0},
      '{MODE_SURR_32, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0}
   };

   surround_to_stereo_downmix dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_chan0     (req_chan0),
      .req_chan1     (req_chan1),
      .req_chan2     (req_chan2),
      .req_chan3     (req_chan3),
      .req_chan4     (req_chan4),
      .req_chan5     (req_chan5),
      .rsp_valid     (rsp_valid),
      .rsp_out_left  (rsp_out_left),
      .rsp_out_right (rsp_out_right),
      .rsp_out_count (rsp_out_count),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // 32-bit wrapping matrix arithmetic, arithmetic shift, keep 16 bits
   function automatic mix_word_type predict_downmix(input mix_mode_type m,
         input logic [SAMPLE_W-1:0] a0, a1, a2, a3, a4);
      bit [31:0] x0, x1, x2, x3, x4, l, r, s, l_sh, r_sh;
      mix_word_type o;
      x0 = {{16{a0[15]}}, a0};
      x1 = {{16{a1[15]}}, a1};
      x2 = {{16{a2[15]}}, a2};
      x3 = {{16{a3[15]}}, a3};
      x4 = {{16{a4[15]}}, a4};
      l = '0;
      r = '0;
      case (m)
         MODE_SURR_32: begin
            s = (x3 + x4) * GAIN_B;
            l = x0 * GAIN_A + x1 * GAIN_B - s;
            r = x2 * GAIN_A + x1 * GAIN_B + s;
         end
         MODE_SURR2_32: begin
            l = x0 * GAIN_A + x1 * GAIN_B - x3 * GAIN_C - x4 * GAIN_D;
            r = x2 * GAIN_A + x1 * GAIN_B + x3 * GAIN_D + x4 * GAIN_C;
         end
         MODE_SURR_22: begin
            s = (x2 + x3) * GAIN_B;
            l = x0 * GAIN_A - s;
            r = x1 * GAIN_A + s;
         end
         MODE_SURR2_22: begin
            l = x0 * GAIN_A - x2 * GAIN_C - x3 * GAIN_D;
            r = x1 * GAIN_A + x3 * GAIN_C + x2 * GAIN_D;
         end
         MODE_3F: begin
            l = x0 * GAIN_A + x1 * GAIN_B;
            r = x2 * GAIN_A + x1 * GAIN_B;
         end
         MODE_3F1R: begin
            l = x0 * GAIN_A + x1 * GAIN_B - x3 * GAIN_B;
            r = x2 * GAIN_A + x1 * GAIN_B + x3 * GAIN_B;
         end
         default: ;
      endcase
      l_sh = $signed(l) >>> FRAC_BITS_DEF;
      r_sh = $signed(r) >>> FRAC_BITS_DEF;
      o.left  = l_sh[15:0];
      o.right = r_sh[15:0];
      o.count = COUNT_STEREO;
      if (m == MODE_MONO_DUP) begin
         o.left  = a0;
         o.right = a0;
      end else if (m == MODE_STEREO_MIX) begin
         o.left  = a0;
         o.right = '0;
         o.count = COUNT_MONO;
      end
      return o;
   endfunction

   task automatic flag_error(input string what, input logic [31:0] want, got);
      $display("%0t: downmix mismatch on %s: want %h got %h", $time, what, want, got);
      error_count++;
   endtask

   // sampled at the rising edge, before the block's own updates land
   always @(posedge clock) begin
      mix_word_type w;
      if (!reset) begin
         if (psel && penable && pready) begin
            csr_done++;
            if (pwrite) begin
               if (paddr == ADDR_MIX_MODE)
                  mode_now = mix_mode_type'(pwdata[2:0]);
            end else if (prdata !== {29'b0, mode_now}) begin
               flag_error("mix_mode readback", {29'b0, mode_now}, prdata);
            end
         end
         if (rsp_valid !== 1'b0) begin
            if (pending_mix.size() == 0) begin
               flag_error("word with nothing pending", '0, {16'b0, rsp_out_left});
            end else begin
               w = pending_mix.pop_front();
               if (rsp_out_left !== w.left)
                  flag_error("out_left", {16'b0, w.left}, {16'b0, rsp_out_left});
               if (rsp_out_right !== w.right)
                  flag_error("out_right", {16'b0, w.right}, {16'b0, rsp_out_right});
               if (rsp_out_count !== w.count)
                  flag_error("out_count", {30'b0, w.count}, {30'b0, rsp_out_count});
            end
         end
         if (start && !busy) begin
            if (pin_on)
               pending_mix.push_back(pin_word);
            else
               pending_mix.push_back(predict_downmix(mode_now, req_chan0, req_chan1,
                                                     req_chan2, req_chan3, req_chan4));
            words_taken++;
         end
      end
   end

   // all tasks below are entered and left at a falling edge
   task automatic send_frame(input logic [SAMPLE_W-1:0] a0, a1, a2, a3, a4, a5);
      int target;
      target = words_taken + 1;
      start     <= 1'b1;
      req_chan0 <= a0;
      req_chan1 <= a1;
      req_chan2 <= a2;
      req_chan3 <= a3;
      req_chan4 <= a4;
      req_chan5 <= a5;
      do @(negedge clock); while (words_taken < target);
   endtask

   // each cycle stays idle with the given odds, so pct is the idle share of cycles
   task automatic maybe_idle(input int pct);
      if ($urandom_range(1, 100) <= pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(1, 100) <= pct);
      end
   endtask

   task automatic settle;
      start <= 1'b0;
      while (pending_mix.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [CSR_DATA_W-1:0] data);
      int target;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= ADDR_MIX_MODE;
      pwdata  <= data;
      @(negedge clock);
      target = csr_done + 1;
      penable <= 1'b1;
      do @(negedge clock); while (csr_done < target);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // write the mode, with junk in the unused upper bits now and then, and read it back
   task automatic set_mode(input mix_mode_type m);
      logic [CSR_DATA_W-1:0] data;
      data = {29'b0, m};
      if ($urandom_range(0, 1))
         data[CSR_DATA_W-1:3] = 29'($urandom);
      settle();
      csr_access(1'b1, data);
      csr_access(1'b0, '0);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'($urandom_range(0, 255) - 128);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      mix_mode_type cur_mode;
      mix_mode_type next_mode;
      int idle_pct;
      reset     = 1'b1;
      start     = 1'b0;
      req_chan0 = '0;
      req_chan1 = '0;
      req_chan2 = '0;
      req_chan3 = '0;
      req_chan4 = '0;
      req_chan5 = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corner frames; first rows rely on the reset mode
      cur_mode = MODE_SURR_32;
      for (int i = 0; i < N_CORNER; i++) begin
         if (corner_rows[i].mode != cur_mode) begin
            set_mode(corner_rows[i].mode);
            cur_mode = corner_rows[i].mode;
         end
         maybe_idle(30);
         pin_on   = corner_rows[i].pinned;
         pin_word = corner_rows[i].want;
         send_frame(corner_rows[i].c0, corner_rows[i].c1, corner_rows[i].c2,
                    corner_rows[i].c3, corner_rows[i].c4, corner_rows[i].c5);
         pin_on = 0;
      end

      // random phases: every mode in turn, then random modes; gaps none / heavy / light
      for (int p = 0; p < N_PHASES; p++) begin
         next_mode = (p < 8) ? mix_mode_type'(3'(p)) : mix_mode_type'(3'($urandom_range(0, 7)));
         case (p % 3)
            0: idle_pct = 0;
            1: idle_pct = 80;
            default: idle_pct = 14;
         endcase
         set_mode(next_mode);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            maybe_idle(idle_pct);
            send_frame(pick_sample(), pick_sample(), pick_sample(),
                       pick_sample(), pick_sample(), pick_sample());
         end
      end

      start <= 1'b0;
      while (pending_mix.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
